/* hw/rtl/rap_pkg.sv */
// ----------------------------------------------------------------------------
// rap_pkg: shared types and constants
// Item types, result kinds, parse phases and fixed limits of the RADIUS
// attribute parser.
// ----------------------------------------------------------------------------
package rap_pkg;

	localparam int unsigned MAX_PACKET   = 4096;
	localparam int unsigned CODE_COUNT   = 64;
	localparam int unsigned ATTR_TYPES   = 256;
	localparam int unsigned HEADER_BYTES = 20;

	localparam logic [1:0] KIND_ATTR = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_FAIL = 2'd2;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TYPE,
		PH_LEN,
		PH_VALUE,
		PH_SWALLOW
	} phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [12:0] packet_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  attr_type;
		logic [11:0] value_offset;
		logic [7:0]  value_length;
		logic [7:0]  packet_code;
		logic [7:0]  packet_identifier;
		logic [15:0] header_length;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} parse_res_t;

endpackage

/* hw/rtl/rap_parse.sv */
// ----------------------------------------------------------------------------
// rap_parse: per-byte packet walker
// Holds the packet walk state and works out, for the byte in the input
// register, up to two result items and the next state.
// ----------------------------------------------------------------------------
module rap_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  rap_pkg::in_item_t  item,
	input  logic [63:0]        code_mask,
	output rap_pkg::parse_res_t res
);
	import rap_pkg::*;

	logic [12:0] pos_q, pos_n;
	phase_t      phase_q, phase_n;
	logic [7:0]  left_q, left_n;
	logic [7:0]  type_q, type_n;
	logic [12:0] start_q, start_n;
	logic [7:0]  code_q, code_n;
	logic [7:0]  ident_q, ident_n;
	logic [15:0] hlen_q, hlen_n;

	logic [7:0]  b;
	logic [12:0] plen;
	logic [13:0] pos1;
	logic        is_last;
	logic        fail;
	logic        ok;
	logic        rec;
	logic [12:0] remain;
	logic [7:0]  left_dec;
	logic [15:0] hlen_full;
	out_item_t   rec_item;
	out_item_t   stat_item;

	always_comb begin
		b         = item.data_byte;
		plen      = item.packet_length;
		pos1      = {1'b0, pos_q} + 14'd1;
		is_last   = pos1 >= {1'b0, plen};
		fail      = 1'b0;
		ok        = 1'b0;
		rec       = 1'b0;
		pos_n     = pos_q;
		phase_n   = phase_q;
		left_n    = left_q;
		type_n    = type_q;
		start_n   = start_q;
		code_n    = code_q;
		ident_n   = ident_q;
		hlen_n    = hlen_q;
		remain    = (plen > start_q) ? plen - start_q : 13'd0;
		left_dec  = (left_q != 8'd0) ? left_q - 8'd1 : left_q;
		hlen_full = hlen_q | {8'h00, b};

		case (phase_q)
			PH_HEADER: begin
				if (pos_q == 13'd0) begin
					code_n  = b;
					ident_n = 8'd0;
					hlen_n  = 16'd0;
					if (32'(plen) < HEADER_BYTES || 32'(plen) > MAX_PACKET)
						fail = 1'b1;
					else if (32'(b) >= CODE_COUNT || !code_mask[b[5:0]])
						fail = 1'b1;
				end else if (pos_q == 13'd1) begin
					ident_n = b;
				end else if (pos_q == 13'd2) begin
					hlen_n = {b, 8'h00};
				end else if (pos_q == 13'd3) begin
					hlen_n = hlen_full;
					if (hlen_full > {3'b000, plen})
						fail = 1'b1;
				end
				if (!fail && 32'(pos1) >= HEADER_BYTES)
					phase_n = PH_TYPE;
			end
			PH_TYPE: begin
				if (!is_last) begin
					type_n  = b;
					start_n = pos_q;
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				if (b < 8'd2 || {5'b00000, b} > remain) begin
					fail = 1'b1;
				end else begin
					rec     = 32'(type_q) < ATTR_TYPES;
					left_n  = b - 8'd2;
					phase_n = (b == 8'd2) ? PH_TYPE : PH_VALUE;
				end
			end
			PH_VALUE: begin
				left_n = left_dec;
				if (left_dec == 8'd0)
					phase_n = PH_TYPE;
			end
			default: begin
			end
		endcase

		if (!fail && is_last && phase_n != PH_SWALLOW) begin
			if (phase_n == PH_TYPE)
				ok = 1'b1;
			else
				fail = 1'b1;
		end

		if (fail)
			phase_n = PH_SWALLOW;

		if (is_last) begin
			pos_n   = 13'd0;
			phase_n = PH_HEADER;
			left_n  = 8'd0;
			type_n  = 8'd0;
			start_n = 13'd0;
		end else begin
			pos_n = pos1[12:0];
		end

		rec_item.kind              = KIND_ATTR;
		rec_item.attr_type         = type_q;
		rec_item.value_offset      = start_q[11:0] + 12'd2;
		rec_item.value_length      = b - 8'd2;
		rec_item.packet_code       = code_n;
		rec_item.packet_identifier = ident_n;
		rec_item.header_length     = hlen_n;
		rec_item.last              = 1'b0;

		stat_item.kind              = fail ? KIND_FAIL : KIND_OK;
		stat_item.attr_type         = 8'd0;
		stat_item.value_offset      = 12'd0;
		stat_item.value_length      = 8'd0;
		stat_item.packet_code       = code_n;
		stat_item.packet_identifier = ident_n;
		stat_item.header_length     = hlen_n;
		stat_item.last              = 1'b1;

		res.count  = {1'b0, rec} + {1'b0, ok | fail};
		res.first  = rec ? rec_item : stat_item;
		res.second = stat_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 13'd0;
			phase_q <= PH_HEADER;
			left_q  <= 8'd0;
			type_q  <= 8'd0;
			start_q <= 13'd0;
			code_q  <= 8'd0;
			ident_q <= 8'd0;
			hlen_q  <= 16'd0;
		end else if (advance) begin
			pos_q   <= pos_n;
			phase_q <= phase_n;
			left_q  <= left_n;
			type_q  <= type_n;
			start_q <= start_n;
			code_q  <= code_n;
			ident_q <= ident_n;
			hlen_q  <= hlen_n;
		end
	end

endmodule

/* hw/rtl/rap_out_queue.sv */
// ----------------------------------------------------------------------------
// rap_out_queue: two-entry result queue
// Takes up to two result items per cycle and presents them one at a time
// on the output channel; the head entry is the output register.
// ----------------------------------------------------------------------------
module rap_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_cnt,
	input  rap_pkg::out_item_t push_first,
	input  rap_pkg::out_item_t push_second,
	input  logic               out_stall,
	output logic               out_valid,
	output rap_pkg::out_item_t out_item,
	output logic [1:0]         occ
);
	import rap_pkg::*;

	logic [1:0] cnt_q, cnt_n;
	logic [1:0] rem;
	logic       pop;
	out_item_t  e0_q, e1_q, e0_n, e1_n, head;

	always_comb begin
		pop   = (cnt_q != 2'd0) && !out_stall;
		rem   = cnt_q - {1'b0, pop};
		head  = pop ? e1_q : e0_q;
		e0_n  = (rem != 2'd0) ? head : push_first;
		if (rem == 2'd2)
			e1_n = e1_q;
		else if (rem == 2'd1)
			e1_n = push_first;
		else
			e1_n = push_second;
		cnt_n = rem + push_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_n;
	end

	always_ff @(posedge clk) begin
		e0_q <= e0_n;
		e1_q <= e1_n;
	end

	assign out_valid = cnt_q != 2'd0;
	assign out_item  = e0_q;
	assign occ       = cnt_q;

endmodule

/* hw/rtl/radius_attribute_parser_top.sv */
// Path: an accepted byte waits in the input register; its results are worked out from it
// combinationally and pushed into the result queue, whose head entry is the output register.
// Throughput: one byte per cycle while the queue has room for the byte's results; the queue is
// checked without the item leaving it that cycle, so a full queue holds bytes with results.
// Reset: asynchronous, clears the packet walk, the result queue and the code mask.
// ----------------------------------------------------------------------------
// radius_attribute_parser_top: RADIUS attribute parser
// Checks the RADIUS header of a byte stream, walks its attributes and emits
// one record per attribute and a status item per packet.
// ----------------------------------------------------------------------------
module radius_attribute_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rap_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output rap_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [63:0]        cfg_wdata
);
	import rap_pkg::*;

	logic        valid_s1;
	in_item_t    item_s1;
	logic [63:0] mask_q;
	logic        advance;
	logic        in_take;
	logic [1:0]  occ;
	logic [2:0]  fill;
	logic [1:0]  push_cnt;
	parse_res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_q <= 64'd0;
		else if (cfg_we)
			mask_q <= cfg_wdata;
	end

	assign fill     = {1'b0, occ} + {1'b0, res.count};
	assign advance  = valid_s1 && (fill <= 3'd2);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign push_cnt = advance ? res.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take)
			item_s1 <= in_item;
	end

	rap_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.code_mask (mask_q),
		.res       (res)
	);

	rap_out_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_cnt    (push_cnt),
		.push_first  (res.first),
		.push_second (res.second),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_item    (out_item),
		.occ         (occ)
	);

`ifndef ASSERT_OFF
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ != 2'd3) else $error("result queue overfilled");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1) else $error("input stalled with empty stage");

	a_pair_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.count == 2'd2) |-> occ == 2'd0)
		else $error("two results pushed into busy queue");

	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.last == (out_item.kind != KIND_ATTR)))
		else $error("last flag does not match result kind");
`endif

endmodule

/* sim/radius_parse_checker.sv */
// ----------------------------------------------------------------------------
// radius_parse_checker: result predictor and scoreboard
// Watches the byte, result and mask ports of the RADIUS attribute parser,
// walks each accepted byte through its own copy of the header and attribute
// state, and compares every result item field by field with the oldest one
// it predicted. Mismatches and unexpected items are counted for the top.
// ----------------------------------------------------------------------------
module radius_parse_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  rap_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_stall,
	input  rap_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [63:0]        cfg_wdata,
	output int                 fail_count,
	output int                 pending
);

	import rap_pkg::*;

	logic [63:0]   accept_mask;
	logic [12:0]   byte_pos;
	phase_t        phase;
	logic [7:0]    bytes_left;
	logic [7:0]    cur_type;
	int unsigned   attr_at;
	logic          failed;
	logic [7:0]    hdr_code;
	logic [7:0]    hdr_ident;
	logic [15:0]   hdr_len;
	out_item_t     parse_results[$];

	function automatic void queue_result(input logic [1:0] kind, input logic [7:0] atype,
			input logic [11:0] off, input logic [7:0] vlen, input logic fin);
		out_item_t r;
		r.kind              = kind;
		r.attr_type         = atype;
		r.value_offset      = off;
		r.value_length      = vlen;
		r.packet_code       = hdr_code;
		r.packet_identifier = hdr_ident;
		r.header_length     = hdr_len;
		r.last              = fin;
		parse_results.push_back(r);
	endfunction

	function automatic void walk_byte(input in_item_t it);
		logic [7:0]  b;
		int unsigned plen, pos, room;
		bit          at_end, bad;
		b      = it.data_byte;
		plen   = it.packet_length;
		pos    = byte_pos;
		at_end = (pos + 1 >= plen);
		bad    = 1'b0;
		case (phase)
			PH_HEADER: begin
				if (pos == 0) begin
					hdr_code  = b;
					hdr_ident = '0;
					hdr_len   = '0;
					if (plen < HEADER_BYTES || plen > MAX_PACKET)
						bad = 1'b1;
					else if (b >= CODE_COUNT || !accept_mask[b[5:0]])
						bad = 1'b1;
				end else if (pos == 1) begin
					hdr_ident = b;
				end else if (pos == 2) begin
					hdr_len = {b, 8'h00};
				end else if (pos == 3) begin
					hdr_len[7:0] = b;
					if (hdr_len > plen)
						bad = 1'b1;
				end
				if (!bad && pos + 1 >= HEADER_BYTES)
					phase = PH_TYPE;
			end
			PH_TYPE: begin
				if (!at_end) begin
					cur_type = b;
					attr_at  = pos;
					phase    = PH_LEN;
				end
			end
			PH_LEN: begin
				room = (plen > attr_at) ? plen - attr_at : 0;
				if (b < 2 || b > room) begin
					bad = 1'b1;
				end else begin
					if (cur_type < ATTR_TYPES)
						queue_result(KIND_ATTR, cur_type, 12'(attr_at + 2), b - 8'd2, 1'b0);
					bytes_left = b - 8'd2;
					phase = (bytes_left == 0) ? PH_TYPE : PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (bytes_left > 0)
					bytes_left--;
				if (bytes_left == 0)
					phase = PH_TYPE;
			end
			default: ;
		endcase
		if (!bad && at_end && phase != PH_SWALLOW) begin
			if (phase == PH_TYPE)
				queue_result(KIND_OK, '0, '0, '0, 1'b1);
			else
				bad = 1'b1;
		end
		if (bad) begin
			queue_result(KIND_FAIL, '0, '0, '0, 1'b1);
			failed = 1'b1;
			phase  = PH_SWALLOW;
		end
		if (at_end) begin
			byte_pos   = '0;
			phase      = PH_HEADER;
			bytes_left = '0;
			cur_type   = '0;
			attr_at    = 0;
			failed     = 1'b0;
		end else begin
			byte_pos = 13'(pos + 1);
		end
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			accept_mask = '0;
			byte_pos    = '0;
			phase       = PH_HEADER;
			bytes_left  = '0;
			cur_type    = '0;
			attr_at     = 0;
			failed      = 1'b0;
			hdr_code    = '0;
			hdr_ident   = '0;
			hdr_len     = '0;
			parse_results.delete();
			fail_count  = 0;
			pending    <= 0;
		end else begin
			if (cfg_we)
				accept_mask = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (parse_results.size() == 0) begin
					$error("unexpected result item, kind %0d", out_item.kind);
					fail_count++;
				end else begin
					want = parse_results.pop_front();
					check_field("kind", want.kind, out_item.kind);
					check_field("attr_type", want.attr_type, out_item.attr_type);
					check_field("value_offset", want.value_offset, out_item.value_offset);
					check_field("value_length", want.value_length, out_item.value_length);
					check_field("packet_code", want.packet_code, out_item.packet_code);
					check_field("packet_identifier", want.packet_identifier,
						out_item.packet_identifier);
					check_field("header_length", want.header_length, out_item.header_length);
					check_field("last", want.last, out_item.last);
				end
			end
			if (in_valid && !in_stall)
				walk_byte(in_item);
			pending <= parse_results.size();
		end
	end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: RADIUS attribute parser regression
// Feeds packets byte by byte: a short directed set of header failures and a
// minimal packet, then random well-formed, trailing-byte, broken and noise
// packets under several code masks.
// Both channels idle at random; the checker judges every result item.
// ----------------------------------------------------------------------------
module tb;

	import rap_pkg::*;

	typedef enum {
		PK_WELL,
		PK_TRAIL,
		PK_HDR_BIG,
		PK_BAD_LEN,
		PK_OVER,
		PK_CUT
	} pkt_style_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	in_item_t           in_item   = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_item;
	logic               cfg_we    = 1'b0;
	logic [63:0]        cfg_wdata = '0;
	int                 fail_count;
	int                 pending;

	bit                 calm = 1'b0;
	logic [63:0]        mask_now = '0;
	logic [7:0]         pkt_data[$];
	logic [12:0]        pkt_len[$];

	radius_attribute_parser_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	radius_parse_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 32);
	end

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 32);
	endfunction

	function automatic logic [7:0] pick_code();
		int unsigned c;
		if (mask_now != 0 && $urandom_range(3) != 0) begin
			do c = $urandom_range(63); while (!mask_now[c]);
		end else begin
			c = $urandom_range(255);
		end
		return 8'(c);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic [12:0] len);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{data_byte: b, packet_length: len};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic add_byte(input int unsigned b, input int unsigned len);
		pkt_data.push_back(8'(b));
		pkt_len.push_back(13'(len));
	endtask

	task automatic send_packet();
		foreach (pkt_data[i])
			push_byte(pkt_data[i], pkt_len[i]);
	endtask

	// hold the input idle until every predicted item has come out
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mask(input logic [63:0] m);
		wait_quiet();
		mask_now  = m;
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic build_packet(input int unsigned total, input logic [7:0] code,
			input pkt_style_t style);
		int unsigned hlen, rem, alen, cap, idx, room, cut;
		int unsigned len_at[$];
		pkt_data.delete();
		pkt_len.delete();
		if (style == PK_HDR_BIG)
			hlen = $urandom_range(65535, total + 1);
		else
			hlen = ($urandom_range(3) == 0) ? $urandom_range(total, 0) : total;
		add_byte(code, total);
		add_byte($urandom, total);
		add_byte(hlen >> 8, total);
		add_byte(hlen, total);
		repeat (HEADER_BYTES - 4) add_byte($urandom, total);
		rem = total - HEADER_BYTES - ((style == PK_TRAIL) ? 1 : 0);
		while (rem > 0) begin
			if (rem == 1) begin
				add_byte($urandom, total);
				rem = 0;
			end else begin
				cap  = (rem > 255) ? 255 : rem;
				alen = ($urandom_range(7) == 0) ? $urandom_range(cap, 2)
					: $urandom_range((cap < 16) ? cap : 16, 2);
				if (rem - alen == 1)
					alen = (alen < cap) ? alen + 1 : alen - 1;
				len_at.push_back(pkt_data.size() + 1);
				add_byte($urandom, total);
				add_byte(alen, total);
				repeat (alen - 2) add_byte($urandom, total);
				rem -= alen;
			end
		end
		if (style == PK_TRAIL)
			add_byte($urandom, total);
		if ((style == PK_BAD_LEN || style == PK_OVER) && len_at.size() != 0) begin
			idx  = len_at[$urandom_range(len_at.size() - 1)];
			room = total - (idx - 1);
			if (style == PK_OVER && room < 255)
				pkt_data[idx] = 8'($urandom_range(255, room + 1));
			else
				pkt_data[idx] = 8'($urandom_range(1, 0));
		end
		// truncate: only the final kept byte carries the shorter length
		if (style == PK_CUT) begin
			cut = $urandom_range(total - 1, 1);
			while (pkt_data.size() > cut) begin
				void'(pkt_data.pop_back());
				void'(pkt_len.pop_back());
			end
			pkt_len[cut - 1] = 13'(cut);
		end
	endtask

	task automatic run_phase(input int unsigned budget);
		int unsigned sent, roll, total, n, lpos, len;
		pkt_style_t  style;
		sent = 0;
		while (sent < budget) begin
			roll  = $urandom_range(99);
			total = ($urandom_range(7) == 0) ? $urandom_range(300, 20)
				: $urandom_range(64, 20);
			if (roll >= 93) begin
				pkt_data.delete();
				pkt_len.delete();
				n    = $urandom_range(24, 1);
				lpos = 0;
				for (int i = 0; i < n; i++) begin
					len = (i == n - 1) ? $urandom_range(lpos + 1, 1) : $urandom_range(8191, 1);
					add_byte($urandom, len);
					lpos = (lpos + 1 >= len) ? 0 : lpos + 1;
				end
			end else begin
				style = (roll < 40) ? PK_WELL : (roll < 55) ? PK_TRAIL
					: (roll < 65) ? PK_HDR_BIG : (roll < 75) ? PK_BAD_LEN
					: (roll < 85) ? PK_OVER : PK_CUT;
				if (style == PK_TRAIL && total < HEADER_BYTES + 1)
					total = HEADER_BYTES + 1;
				build_packet(total, pick_code(), style);
			end
			sent += pkt_data.size();
			send_packet();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mask('1);

		pkt_data.delete();
		pkt_len.delete();
		add_byte(8'd1, 1);
		add_byte(8'd0, 8191);
		add_byte(8'hFF, 2);
		add_byte(8'hFF, HEADER_BYTES);
		add_byte(8'h00, 2);
		add_byte(8'd1, HEADER_BYTES);
		add_byte(8'h5A, HEADER_BYTES);
		add_byte(8'hFF, HEADER_BYTES);
		add_byte(8'hFF, HEADER_BYTES);
		add_byte(8'h00, 5);
		add_byte(8'd63, HEADER_BYTES);
		add_byte(8'hA5, HEADER_BYTES);
		add_byte(8'h00, 3);
		send_packet();
		build_packet(HEADER_BYTES + 2, 8'd2, PK_WELL);
		send_packet();

		write_mask({$urandom, $urandom});
		run_phase(350);

		write_mask(64'h8000_0000_0000_0001);
		calm = 1'b1;
		run_phase(300);
		wait_quiet();
		calm = 1'b0;

		write_mask('0);
		run_phase(100);

		write_mask({$urandom, $urandom});
		run_phase(400);

		write_mask('1);
		run_phase(450);

		wait_quiet();
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/rap_pkg.sv
hw/rtl/rap_parse.sv
hw/rtl/rap_out_queue.sv
hw/rtl/radius_attribute_parser_top.sv
sim/radius_parse_checker.sv
sim/tb.sv
